@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the frame slot cache.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FSCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FSCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/fsca_pkg.sv @@
// Shared constants and types for the frame slot cache allocator.
// No dependencies.
package fsca_pkg;

  localparam int SLOTS = 32;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TAG_W = 15;
  localparam int OUT_IDX_W = 5;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic clear;  // drop every used mark
    logic load;   // selected cell takes new tags
    logic mark;   // selected cell sets its used mark
  } cell_cmd_t;

endpackage

@@ rtl/fsca_cell.sv @@
// One cache slot: animation and frame tags, used mark and tag compare.
// Depends on fsca_pkg.
module fsca_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [fsca_pkg::TAG_W-1:0] cmp_anim,
  input  logic [fsca_pkg::TAG_W-1:0] cmp_frame,
  input  logic [fsca_pkg::TAG_W-1:0] wr_anim,
  input  logic [fsca_pkg::TAG_W-1:0] wr_frame,
  input  fsca_pkg::cell_cmd_t      cmd,
  input  logic                     sel,
  output logic                     match,
  output logic                     used
);

  logic [fsca_pkg::TAG_W-1:0] anim_tag;
  logic [fsca_pkg::TAG_W-1:0] frame_tag;

  // Tags are part of the visible state: zero tags must hit after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      anim_tag  <= '0;
      frame_tag <= '0;
      used      <= 1'b0;
    end else begin
      if (sel && cmd.load) begin
        anim_tag  <= wr_anim;
        frame_tag <= wr_frame;
      end
      if (cmd.clear) begin
        used <= 1'b0;
      end else if (sel && cmd.mark) begin
        used <= 1'b1;
      end
    end
  end

  assign match = (anim_tag == cmp_anim) && (frame_tag == cmp_frame);

endmodule

@@ rtl/fsca_pick.sv @@
// Lowest-set-bit picker: one-hot of the lowest set bit and its index.
// Depends on fsca_pkg.
module fsca_pick (
  input  logic [fsca_pkg::SLOTS-1:0] vec,
  output logic [fsca_pkg::SLOTS-1:0] onehot,
  output logic [fsca_pkg::IDX_W-1:0] idx,
  output logic                       any
);

  always_comb begin
    onehot = vec & (~vec + {{(fsca_pkg::SLOTS-1){1'b0}}, 1'b1});
    idx    = '0;
    for (int i = 0; i < fsca_pkg::SLOTS; i++) begin
      if (onehot[i]) begin
        idx = idx | fsca_pkg::IDX_W'(i);
      end
    end
    any = |vec;
  end

endmodule

@@ rtl/frame_slot_cache_allocator.sv @@
// Top level of the frame slot cache allocator: slot cells, pickers, control.
// Depends on fsca_pkg, fsca_cell, fsca_pick and assert_macros.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_stall  | action, anim_number, frame_number
//   out     | out_valid / out_stall| slot_index, was_hit, cache_full
//
// For each word the accept edge registers the tag compare of every cell;
// the decide state then picks the slot, updates the cells and loads the
// output register. The next word is taken as soon as the block is idle again.
// A result waiting on out_stall holds the following word in the decide state.
// rst clears every tag, used mark and the next-slot pointer.
module frame_slot_cache_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [fsca_pkg::TAG_W-1:0]    anim_number,
  input  logic [fsca_pkg::TAG_W-1:0]    frame_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fsca_pkg::OUT_IDX_W-1:0] slot_index,
  output logic                          was_hit,
  output logic                          cache_full
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DEC  = 1'b1;

  logic                        state;
  logic                        state_next;
  logic                        req_action;
  logic [fsca_pkg::TAG_W-1:0]  req_anim;
  logic [fsca_pkg::TAG_W-1:0]  req_frame;
  logic [fsca_pkg::SLOTS-1:0]  match_vec;
  logic [fsca_pkg::SLOTS-1:0]  match_live;
  logic [fsca_pkg::SLOTS-1:0]  used_vec;
  logic [fsca_pkg::IDX_W-1:0]  next_pointer;

  logic [fsca_pkg::SLOTS-1:0]  hit_onehot;
  logic [fsca_pkg::IDX_W-1:0]  hit_idx;
  logic                        hit_any;
  logic [fsca_pkg::SLOTS-1:0]  free_vec;
  logic [fsca_pkg::SLOTS-1:0]  free_hi;
  logic [fsca_pkg::SLOTS-1:0]  free_pick;
  logic [fsca_pkg::SLOTS-1:0]  free_onehot;
  logic [fsca_pkg::IDX_W-1:0]  free_idx;
  logic                        free_any;

  logic                        in_accept;
  logic                        commit;
  fsca_pkg::cell_cmd_t         cmd;
  logic [fsca_pkg::SLOTS-1:0]  sel_vec;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign commit    = (state == S_DEC) && (!out_valid || !out_stall);

  for (genvar g = 0; g < fsca_pkg::SLOTS; g++) begin : g_cell
    fsca_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmp_anim  (anim_number),
      .cmp_frame (frame_number),
      .wr_anim   (req_anim),
      .wr_frame  (req_frame),
      .cmd       (cmd),
      .sel       (sel_vec[g]),
      .match     (match_live[g]),
      .used      (used_vec[g])
    );
  end

  fsca_pick u_pick_hit (
    .vec    (match_vec),
    .onehot (hit_onehot),
    .idx    (hit_idx),
    .any    (hit_any)
  );

  // Round-robin: prefer free slots at or above the pointer, else wrap.
  always_comb begin
    free_vec = ~used_vec;
    for (int i = 0; i < fsca_pkg::SLOTS; i++) begin
      free_hi[i] = free_vec[i] && (fsca_pkg::IDX_W'(i) >= next_pointer);
    end
    free_pick = (|free_hi) ? free_hi : free_vec;
  end

  fsca_pick u_pick_free (
    .vec    (free_pick),
    .onehot (free_onehot),
    .idx    (free_idx),
    .any    (free_any)
  );

  always_comb begin
    cmd     = '0;
    sel_vec = '0;
    if (commit) begin
      if (req_action == fsca_pkg::ACT_CLEAR) begin
        cmd.clear = 1'b1;
      end else if (hit_any) begin
        cmd.mark = 1'b1;
        sel_vec  = hit_onehot;
      end else if (free_any) begin
        cmd.mark = 1'b1;
        cmd.load = 1'b1;
        sel_vec  = free_onehot;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept) state_next = S_DEC;
      S_DEC:  if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      next_pointer <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // Advance the pointer past a newly allocated slot.
      if (commit && req_action == fsca_pkg::ACT_LOAD && !hit_any && free_any) begin
        if (free_idx == fsca_pkg::IDX_W'(fsca_pkg::SLOTS - 1)) begin
          next_pointer <= '0;
        end else begin
          next_pointer <= free_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_action <= action;
      req_anim   <= anim_number;
      req_frame  <= frame_number;
      match_vec  <= match_live;
    end
    if (commit) begin
      if (req_action == fsca_pkg::ACT_CLEAR) begin
        slot_index <= '0;
        was_hit    <= 1'b0;
        cache_full <= 1'b0;
      end else if (hit_any) begin
        slot_index <= fsca_pkg::OUT_IDX_W'(hit_idx);
        was_hit    <= 1'b1;
        cache_full <= 1'b0;
      end else if (free_any) begin
        slot_index <= fsca_pkg::OUT_IDX_W'(free_idx);
        was_hit    <= 1'b0;
        cache_full <= 1'b0;
      end else begin
        slot_index <= '0;
        was_hit    <= 1'b0;
        cache_full <= 1'b1;
      end
    end
  end

`include "assert_macros.svh"

  `FSCA_ASSERT(a_accept_to_dec, in_accept |=> (state == S_DEC), "accept did not enter decide")
  `FSCA_ASSERT(a_hit_keeps_ptr, (commit && req_action == fsca_pkg::ACT_LOAD && hit_any) |=> $stable(next_pointer), "hit moved the pointer")
  `FSCA_ASSERT(a_full_no_hit, (out_valid && cache_full) |-> (!was_hit && slot_index == '0), "full result carries a slot")
  `FSCA_ASSERT(a_sel_onehot, $onehot0(sel_vec), "more than one cell selected")

endmodule

@@ tb/sv/frame_slot_cache_allocator_checker.sv @@
// Checker for the frame slot cache allocator: watches both channels, predicts each result
// from its own copy of the tags, used marks and next-slot pointer, and compares.
// Depends on fsca_pkg.
module frame_slot_cache_allocator_checker
  import fsca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 action,
  input  logic [TAG_W-1:0]     anim_number,
  input  logic [TAG_W-1:0]     frame_number,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [OUT_IDX_W-1:0] slot_index,
  input  logic                 was_hit,
  input  logic                 cache_full,
  output int                   error_count,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] slot;
    logic                 hit;
    logic                 full;
  } slot_grant_t;

  logic [TAG_W-1:0] anim_tags  [SLOTS];
  logic [TAG_W-1:0] frame_tags [SLOTS];
  logic             used_marks [SLOTS];
  int               next_slot;
  slot_grant_t      grant_q[$];

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  function automatic void clear_cache();
    for (int i = 0; i < SLOTS; i++) begin
      anim_tags[i]  = '0;
      frame_tags[i] = '0;
      used_marks[i] = 1'b0;
    end
    next_slot = 0;
  endfunction

  // Lowest matching slot wins a hit; a miss takes the first free slot from next_slot on.
  function automatic slot_grant_t serve_request(input logic act,
                                                input logic [TAG_W-1:0] anim,
                                                input logic [TAG_W-1:0] frame);
    slot_grant_t g;
    int s;
    g.slot = '0;
    g.hit  = 1'b0;
    g.full = 1'b0;
    if (act == ACT_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) used_marks[i] = 1'b0;
      return g;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (anim_tags[i] == anim && frame_tags[i] == frame) begin
        used_marks[i] = 1'b1;
        g.slot = OUT_IDX_W'(i);
        g.hit  = 1'b1;
        return g;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      s = (next_slot + i) % SLOTS;
      if (!used_marks[s]) begin
        anim_tags[s]  = anim;
        frame_tags[s] = frame;
        used_marks[s] = 1'b1;
        next_slot     = (s + 1) % SLOTS;
        g.slot        = OUT_IDX_W'(s);
        return g;
      end
    end
    // every slot in use: nothing changes
    g.full = 1'b1;
    return g;
  endfunction

  always @(posedge clk) begin
    slot_grant_t got;
    slot_grant_t want;
    if (rst) begin
      clear_cache();
      grant_q.delete();
    end else begin
      // compare first: a word accepted at this edge cannot have its result out yet
      if (out_valid && !out_stall) begin
        got.slot = slot_index;
        got.hit  = was_hit;
        got.full = cache_full;
        if (grant_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected result slot_index=%0d was_hit=%0b cache_full=%0b",
                     $realtime, got.slot, got.hit, got.full);
        end else begin
          want = grant_q.pop_front();
          if (got.slot !== want.slot || got.hit !== want.hit || got.full !== want.full) begin
            error_count++;
            if (error_count <= 10)
              $display({"%0t: expected slot_index=%0d was_hit=%0b cache_full=%0b, ",
                        "got slot_index=%0d was_hit=%0b cache_full=%0b"},
                       $realtime, want.slot, want.hit, want.full,
                       got.slot, got.hit, got.full);
          end
        end
      end
      if (in_valid && !in_stall)
        grant_q.push_back(serve_request(action, anim_number, frame_number));
    end
    outstanding = grant_q.size();
  end

endmodule

@@ tb/sv/frame_slot_cache_allocator_test.sv @@
// Top of the frame slot cache allocator testbench: clock, reset, request stimulus and
// random stalls on the result side, with the verdict. Depends on fsca_pkg,
// frame_slot_cache_allocator and frame_slot_cache_allocator_checker.
module frame_slot_cache_allocator_test;
  import fsca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_TARGET = 1050;
  localparam int POOL_MAX    = 48;
  localparam logic [TAG_W-1:0] TAG_MAX = '1;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic [TAG_W-1:0]     anim_number;
  logic [TAG_W-1:0]     frame_number;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_IDX_W-1:0] slot_index;
  logic                 was_hit;
  logic                 cache_full;
  int                   error_count;
  int                   outstanding;

  int                   words_sent;
  bit                   tx_calm;
  bit                   rx_calm;
  logic [TAG_W-1:0]     pool_anim  [POOL_MAX];
  logic [TAG_W-1:0]     pool_frame [POOL_MAX];

  frame_slot_cache_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .anim_number(anim_number), .frame_number(frame_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot_index(slot_index), .was_hit(was_hit), .cache_full(cache_full)
  );

  frame_slot_cache_allocator_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .anim_number(anim_number), .frame_number(frame_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot_index(slot_index), .was_hit(was_hit), .cache_full(cache_full),
    .error_count(error_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Drive one request word after a random gap and hold it until accepted.
  task automatic send_word(input logic act, input logic [TAG_W-1:0] anim,
                           input logic [TAG_W-1:0] frame);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    anim_number  <= anim;
    frame_number <= frame;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Hold off until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Result side: random stall before each word, with calm stretches.
  initial begin
    int n;
    out_stall = 1'b0;
    rx_calm   = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
      n = rx_calm ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    int ps;
    int burst_len;
    int r;
    int k;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = ACT_LOAD;
    anim_number  = '0;
    frame_number = '0;
    words_sent   = 0;
    tx_calm      = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // tags reset to zero: animation 0 frame 0 hits, lowest of all matching slots
    send_word(ACT_LOAD, '0, '0);
    send_word(ACT_LOAD, '0, '0);
    send_word(ACT_LOAD, TAG_MAX, TAG_MAX);
    send_word(ACT_LOAD, TAG_MAX, '0);
    send_word(ACT_LOAD, '0, TAG_MAX);
    send_word(ACT_LOAD, 15'h5555, 15'h2AAA);
    send_word(ACT_LOAD, 15'h2AAA, 15'h5555);
    // hit on a loaded slot leaves the pointer alone
    send_word(ACT_LOAD, TAG_MAX, TAG_MAX);
    send_word(ACT_LOAD, 15'h0001, 15'h0001);
    // clear ignores the tag fields
    send_word(ACT_CLEAR, TAG_MAX, TAG_MAX);
    send_word(ACT_LOAD, '0, '0);
    send_word(ACT_LOAD, 15'h4000, 15'h0002);
    send_word(ACT_LOAD, 15'h5555, 15'h2AAA);
    send_word(ACT_CLEAR, '0, '0);
    tx_calm = 1'b1;
    send_word(ACT_LOAD, 15'h0100, 15'h0200);
    send_word(ACT_LOAD, 15'h0100, 15'h0200);
    send_word(ACT_CLEAR, 15'h2AAA, 15'h5555);
    tx_calm = 1'b0;
    drain_results();

    // bursts over a small pool of frames so hits, refills and a full cache all occur
    while (words_sent < WORD_TARGET) begin
      tx_calm   = ($urandom_range(0, 3) == 0);
      ps        = $urandom_range(4, POOL_MAX);
      burst_len = $urandom_range(20, 80);
      for (k = 0; k < ps; k++) begin
        pool_anim[k]  = TAG_W'($urandom_range(0, 32767));
        pool_frame[k] = TAG_W'($urandom_range(0, 32767));
      end
      for (k = 0; k < burst_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          send_word(ACT_CLEAR, TAG_W'($urandom_range(0, 32767)),
                    TAG_W'($urandom_range(0, 32767)));
        else if (r < 10)
          send_word(ACT_LOAD, TAG_W'($urandom_range(0, 32767)),
                    TAG_W'($urandom_range(0, 32767)));
        else begin
          r = $urandom_range(0, ps - 1);
          send_word(ACT_LOAD, pool_anim[r], pool_frame[r]);
        end
      end
      if ($urandom_range(0, 9) < 7)
        send_word(ACT_CLEAR, TAG_W'($urandom_range(0, 32767)),
                  TAG_W'($urandom_range(0, 32767)));
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
